### hw/rtl/ptres_pkg.sv
// Shared types, constants and elaboration-time tables for the texel resolve block.
package ptres_pkg;

  localparam int IN_W            = 16;
  localparam int CHANNEL_BITS    = 16;
  localparam int BYTE_W          = 8;
  localparam int SUPERSAMPLE_DEF = 3;
  localparam int SUM_W           = 36;
  localparam int ASUM_W          = 20;
  localparam int CNT_W           = 5;
  localparam int XFRAC           = 40;
  localparam int LFRAC           = 30;
  localparam int Q_W             = XFRAC + 1;
  localparam int LX_W            = 40;
  localparam int STEP_W          = 6;
  localparam int MANT_W          = 32;
  localparam int E_W             = 6;
  localparam int LIN_W           = 9;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W          = $clog2(QDEPTH + 1);
  localparam int NUM_CH          = 3;
  localparam int CH_W            = 2;
  localparam int TAB_N           = 256;

  localparam logic [IN_W-1:0] FULL_SCALE = IN_W'((64'd1 << CHANNEL_BITS) - 64'd1);
  localparam logic [63:0] LIN_LIMIT = (64'd31308 << XFRAC) / 64'd10000000;

  // One texel's worth of accumulated sums
  typedef struct packed {
    logic [SUM_W-1:0]  sum_red;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_blue;
    logic [ASUM_W-1:0] sum_alpha;
    logic [CNT_W-1:0]  samples;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_ADIV, BK_CSTART, BK_CDIV, BK_CNORM, BK_LOG,
    BK_LXSET, BK_SEARCH, BK_LIN1, BK_LIN2, BK_NEXT, BK_OUT
  } bk_state_t;

  typedef logic [TAB_N-1:0][LX_W-1:0] thr_tab_t;

  // Fixed-point log2 with 30 fraction bits by repeated squaring
  function automatic logic [63:0] log2_fx(input logic [63:0] v);
    int e;
    logic [63:0] m;
    logic [63:0] f;
    e = 63;
    while (e > 0 && v[e] == 1'b0) e = e - 1;
    if (e >= 31) m = v >> (e - 31);
    else m = v << (31 - e);
    f = 64'd0;
    for (int i = 0; i < LFRAC; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    return (64'(e) << LFRAC) + f;
  endfunction

  // Per-byte decision thresholds of the sRGB power segment
  function automatic thr_tab_t build_thr_tab();
    thr_tab_t t;
    logic [63:0] lden;
    logic [63:0] lu;
    lden = log2_fx(64'd53805);
    for (int b = 0; b < TAB_N; b++) begin
      lu = 64'd12 * (log2_fx(64'(200 * b + 2705)) - lden);
      t[b] = lu[LX_W-1:0];
    end
    return t;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr_tab();

endpackage

### hw/rtl/ptres_front.sv
// Sample intake: premultiply and accumulate, hand off one job per texel.
module ptres_front import ptres_pkg::*; #(
  parameter int SUPERSAMPLE = SUPERSAMPLE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IN_W-1:0] in_sample_red,
  input  logic [IN_W-1:0] in_sample_green,
  input  logic [IN_W-1:0] in_sample_blue,
  input  logic [IN_W-1:0] in_sample_alpha,
  input  logic            in_last_sample,
  input  logic            q_full,
  output logic            push,
  output job_t            job
);

  localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(SUPERSAMPLE * SUPERSAMPLE);

  logic [SUM_W-1:0]  sum_red_r, sum_green_r, sum_blue_r;
  logic [SUM_W-1:0]  sum_red_nxt, sum_green_nxt, sum_blue_nxt;
  logic [ASUM_W-1:0] sum_alpha_r, sum_alpha_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IN_W-1:0]   r_m, g_m, b_m, a_m;
  logic [2*IN_W-1:0] pr, pg, pb;
  logic              accept, take;

  // Stall only when the job queue cannot take another texel
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign take     = cnt_r < MAX_SAMPLES;

  // Premultiply and add into the running sums
  always_comb begin
    r_m = in_sample_red   & FULL_SCALE;
    g_m = in_sample_green & FULL_SCALE;
    b_m = in_sample_blue  & FULL_SCALE;
    a_m = in_sample_alpha & FULL_SCALE;
    pr  = r_m * a_m;
    pg  = g_m * a_m;
    pb  = b_m * a_m;
    sum_red_nxt   = sum_red_r;
    sum_green_nxt = sum_green_r;
    sum_blue_nxt  = sum_blue_r;
    sum_alpha_nxt = sum_alpha_r;
    cnt_nxt       = cnt_r;
    if (take) begin
      sum_red_nxt   = sum_red_r   + SUM_W'(pr);
      sum_green_nxt = sum_green_r + SUM_W'(pg);
      sum_blue_nxt  = sum_blue_r  + SUM_W'(pb);
      sum_alpha_nxt = sum_alpha_r + ASUM_W'(a_m);
      cnt_nxt       = cnt_r + CNT_W'(1);
    end
    job.sum_red   = sum_red_nxt;
    job.sum_green = sum_green_nxt;
    job.sum_blue  = sum_blue_nxt;
    job.sum_alpha = sum_alpha_nxt;
    job.samples   = cnt_nxt;
    push = accept && in_last_sample;
  end

  // Advance the accumulators; clear after the last beat of a texel
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_sample)) begin
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
      sum_alpha_r <= '0;
      cnt_r       <= '0;
    end else if (accept) begin
      sum_red_r   <= sum_red_nxt;
      sum_green_r <= sum_green_nxt;
      sum_blue_r  <= sum_blue_nxt;
      sum_alpha_r <= sum_alpha_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/ptres_job_queue.sv
// Short job queue between the accumulator front and the resolve back end.
module ptres_job_queue import ptres_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic nonempty,
  input  logic pop,
  output job_t pop_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = count_r == QCNT_W'(QDEPTH);
  assign nonempty = count_r != '0;
  assign pop_job  = mem_r[rd_ptr_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

### hw/rtl/ptres_back.sv
// Resolve sequencer: alpha average, straight colour divide, sRGB encode.
module ptres_back import ptres_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_texel_red,
  output logic [BYTE_W-1:0] out_texel_green,
  output logic [BYTE_W-1:0] out_texel_blue,
  output logic [BYTE_W-1:0] out_texel_alpha
);

  bk_state_t state_r, state_nxt;

  logic [SUM_W-1:0]  col_sum_r [NUM_CH];
  logic [SUM_W-1:0]  col_sum_nxt [NUM_CH];
  logic [BYTE_W-1:0] col_byte_r [NUM_CH];
  logic [BYTE_W-1:0] col_byte_nxt [NUM_CH];
  logic [SUM_W-1:0]  cden_r, cden_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  den_r, den_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [E_W-1:0]    e_r, e_nxt;
  logic [MANT_W-1:0] m_r, m_nxt;
  logic [LFRAC-1:0]  f_r, f_nxt;
  logic signed [LX_W-1:0] lx_r, lx_nxt;
  logic [BYTE_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LIN_W-1:0]  lin_r, lin_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [BYTE_W-1:0] abyte_r, abyte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] o_red_r, o_green_r, o_blue_r, o_alpha_r;
  logic [BYTE_W-1:0] o_red_nxt, o_green_nxt, o_blue_nxt, o_alpha_nxt;

  logic [SUM_W:0]      rem2;
  logic                ge;
  logic [SUM_W-1:0]    rem_step;
  logic [Q_W-1:0]      q_step;
  logic [SUM_W-1:0]    sa_x, n_x, aden;
  logic [63:0]         sq_prod;
  logic [MANT_W:0]     sq;
  logic [6:0]          dd;
  logic signed [LX_W-1:0] lt;
  logic [BYTE_W:0]     mid_sum;
  logic [BYTE_W-1:0]   mid;
  logic [48:0]         lin_prod;
  logic [17:0]         div10;

  assign out_valid       = out_valid_r;
  assign out_texel_red   = o_red_r;
  assign out_texel_green = o_green_r;
  assign out_texel_blue  = o_blue_r;
  assign out_texel_alpha = o_alpha_r;

  always_comb begin
    // Shared restoring divider step
    rem2     = {rem_r, 1'b0};
    ge       = rem2 >= {1'b0, den_r};
    rem_step = ge ? SUM_W'(rem2 - {1'b0, den_r}) : rem2[SUM_W-1:0];
    q_step   = {q_r[Q_W-2:0], ge};

    // Alpha operands from the incoming job
    sa_x = SUM_W'(job.sum_alpha);
    n_x  = SUM_W'(job.samples);
    aden = (n_x << CHANNEL_BITS) - n_x;

    // Squaring step of the log unit
    sq_prod = 64'(m_r) * 64'(m_r);
    sq      = sq_prod[63:31];

    // Log of the straight colour, scaled for the threshold compare
    dd = {1'b0, e_r} - 7'd40;
    lt = {{3{dd[6]}}, dd, f_r};

    mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + 9'd1;
    mid      = mid_sum[BYTE_W:1];
    lin_prod = 49'(q_r[31:0]) * 49'd32946 + (49'd5 << XFRAC);
    div10    = 18'(lin_r) * 18'd205;

    state_nxt     = state_r;
    col_sum_nxt   = col_sum_r;
    col_byte_nxt  = col_byte_r;
    cden_nxt      = cden_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    f_nxt         = f_r;
    lx_nxt        = lx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lin_nxt       = lin_r;
    ch_nxt        = ch_r;
    abyte_nxt     = abyte_r;
    o_red_nxt     = o_red_r;
    o_green_nxt   = o_green_r;
    o_blue_nxt    = o_blue_r;
    o_alpha_nxt   = o_alpha_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;

    case (state_r)
      BK_IDLE: begin
        // Take a job and set up the alpha average; a zero alpha sum goes straight to output
        if (job_valid) begin
          pop            = 1'b1;
          col_sum_nxt[0] = job.sum_red;
          col_sum_nxt[1] = job.sum_green;
          col_sum_nxt[2] = job.sum_blue;
          cden_nxt       = (sa_x << CHANNEL_BITS) - sa_x;
          rem_nxt        = (sa_x << 9) - (sa_x << 1) + aden;
          den_nxt        = aden << 9;
          q_nxt          = '0;
          step_nxt       = STEP_W'(BYTE_W);
          if (job.sum_alpha == '0) begin
            col_byte_nxt[0] = '0;
            col_byte_nxt[1] = '0;
            col_byte_nxt[2] = '0;
            abyte_nxt       = '0;
            state_nxt       = BK_OUT;
          end else begin
            state_nxt = BK_ADIV;
          end
        end
      end
      BK_ADIV: begin
        rem_nxt  = rem_step;
        q_nxt    = q_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          abyte_nxt = q_step[BYTE_W-1:0];
          ch_nxt    = '0;
          state_nxt = BK_CSTART;
        end
      end
      BK_CSTART: begin
        // Saturate at full scale, otherwise divide to 40 fraction bits
        den_nxt = cden_r;
        e_nxt   = E_W'(XFRAC);
        if (col_sum_r[ch_r] >= cden_r) begin
          q_nxt     = Q_W'(1) << XFRAC;
          state_nxt = BK_CNORM;
        end else begin
          rem_nxt   = col_sum_r[ch_r];
          q_nxt     = '0;
          step_nxt  = STEP_W'(XFRAC);
          state_nxt = BK_CDIV;
        end
      end
      BK_CDIV: begin
        rem_nxt  = rem_step;
        q_nxt    = q_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = (q_step <= Q_W'(LIN_LIMIT)) ? BK_LIN1 : BK_CNORM;
        end
      end
      BK_CNORM: begin
        // Shift up to the leading one, one bit per cycle
        if (q_r[Q_W-1]) begin
          m_nxt     = q_r[Q_W-1 -: MANT_W];
          f_nxt     = '0;
          step_nxt  = STEP_W'(LFRAC);
          state_nxt = BK_LOG;
        end else begin
          q_nxt = {q_r[Q_W-2:0], 1'b0};
          e_nxt = e_r - E_W'(1);
        end
      end
      BK_LOG: begin
        if (sq[MANT_W]) begin
          m_nxt = sq[MANT_W:1];
          f_nxt = {f_r[LFRAC-2:0], 1'b1};
        end else begin
          m_nxt = sq[MANT_W-1:0];
          f_nxt = {f_r[LFRAC-2:0], 1'b0};
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) state_nxt = BK_LXSET;
      end
      BK_LXSET: begin
        lx_nxt    = (lt <<< 2) + lt;
        lo_nxt    = '0;
        hi_nxt    = '1;
        state_nxt = BK_SEARCH;
      end
      BK_SEARCH: begin
        // Binary search over the encode thresholds
        if (lo_r < hi_r) begin
          if ($signed(THR_TAB[mid]) <= lx_r) lo_nxt = mid;
          else hi_nxt = mid - BYTE_W'(1);
        end else begin
          col_byte_nxt[ch_r] = lo_r;
          state_nxt          = BK_NEXT;
        end
      end
      BK_LIN1: begin
        lin_nxt   = lin_prod[48:XFRAC];
        state_nxt = BK_LIN2;
      end
      BK_LIN2: begin
        col_byte_nxt[ch_r] = BYTE_W'(div10[17:11]);
        state_nxt          = BK_NEXT;
      end
      BK_NEXT: begin
        if (ch_r == CH_W'(NUM_CH - 1)) begin
          state_nxt = BK_OUT;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = BK_CSTART;
        end
      end
      BK_OUT: begin
        // Load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          o_red_nxt     = col_byte_r[0];
          o_green_nxt   = col_byte_r[1];
          o_blue_nxt    = col_byte_r[2];
          o_alpha_nxt   = abyte_r;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    col_sum_r  <= col_sum_nxt;
    col_byte_r <= col_byte_nxt;
    cden_r     <= cden_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    e_r        <= e_nxt;
    m_r        <= m_nxt;
    f_r        <= f_nxt;
    lx_r       <= lx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lin_r      <= lin_nxt;
    ch_r       <= ch_nxt;
    abyte_r    <= abyte_nxt;
    o_red_r    <= o_red_nxt;
    o_green_r  <= o_green_nxt;
    o_blue_r   <= o_blue_nxt;
    o_alpha_r  <= o_alpha_nxt;
  end

endmodule

### hw/rtl/premultiplied_texel_resolve_top.sv
// Top level of the premultiplied texel resolve block.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | sample_red/green/blue/alpha, last_sample
//   out_    | output    | out_valid/out_stall| texel_red/green/blue/alpha
//
// Samples are taken one per cycle; the accumulator front never waits on the back end
// unless the two-entry job queue is full.
// In the back end each texel runs an 8-step alpha divide, then per colour either a
// saturation or a 40-step divide, and then either a linear path or a normalize,
// a 30-step squaring log and an 8-step threshold search.
// A texel with zero alpha sum skips the divides and goes straight to the output state.
// Reset (rst_n low, synchronous) clears the sums, the queue and the output valid flag.
// A stalled output holds its beat; the back end waits in its output state.
module premultiplied_texel_resolve_top import ptres_pkg::*; #(
  parameter int SUPERSAMPLE = SUPERSAMPLE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IN_W-1:0]   in_sample_red,
  input  logic [IN_W-1:0]   in_sample_green,
  input  logic [IN_W-1:0]   in_sample_blue,
  input  logic [IN_W-1:0]   in_sample_alpha,
  input  logic              in_last_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_texel_red,
  output logic [BYTE_W-1:0] out_texel_green,
  output logic [BYTE_W-1:0] out_texel_blue,
  output logic [BYTE_W-1:0] out_texel_alpha
);

  logic q_full, q_push, q_nonempty, q_pop;
  job_t push_job, pop_job;

  ptres_front #(.SUPERSAMPLE(SUPERSAMPLE)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_red   (in_sample_red),
    .in_sample_green (in_sample_green),
    .in_sample_blue  (in_sample_blue),
    .in_sample_alpha (in_sample_alpha),
    .in_last_sample  (in_last_sample),
    .q_full          (q_full),
    .push            (q_push),
    .job             (push_job)
  );

  ptres_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .pop_job  (pop_job)
  );

  ptres_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_nonempty),
    .job             (pop_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_texel_red   (out_texel_red),
    .out_texel_green (out_texel_green),
    .out_texel_blue  (out_texel_blue),
    .out_texel_alpha (out_texel_alpha)
  );

endmodule
